### rtl/rgbc_pkg.sv
// ----------------------------------------------------------------------------
// rgbc_pkg
// Shared types and constants of the 3x3 bgr convolution block.
// ----------------------------------------------------------------------------
package rgbc_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 12;
  localparam int KERNEL_W  = 24;
  localparam int PIX_W     = 24;
  localparam int TAPS      = 9;

  localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);
  localparam logic [WIDTH_W-1:0]  WIDTH_RST    = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST   = HEIGHT_W'(480);
  localparam logic [KERNEL_W-1:0] KERNEL_TOP_RST = KERNEL_W'(0);
  localparam logic [KERNEL_W-1:0] KERNEL_MID_RST = KERNEL_W'(256);
  localparam logic [KERNEL_W-1:0] KERNEL_BOT_RST = KERNEL_W'(0);

  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_KERNEL_TOP   = 3'd2,
    CFG_KERNEL_MID   = 3'd3,
    CFG_KERNEL_BOT   = 3'd4
  } cfg_idx_t;

  // one 8-bit value per window tap, row-major from the top-left corner
  typedef logic [TAPS-1:0][7:0] tap_arr_t;

  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } lane_ctrl_t;

endpackage

### rtl/rgbc_ram.sv
// ----------------------------------------------------------------------------
// rgbc_ram
// Generic simple dual-port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module rgbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/rgbc_lane.sv
// ----------------------------------------------------------------------------
// rgbc_lane
// One color channel: nine weighted taps, summed in two steps and saturated.
// ----------------------------------------------------------------------------
module rgbc_lane import rgbc_pkg::*; (
  input  logic       clk,
  input  lane_ctrl_t ctrl,
  input  tap_arr_t   pix,
  input  tap_arr_t   wgt,
  output logic [7:0] sat
);

  logic [TAPS-1:0][15:0] prod;
  logic [2:0][17:0]      psum;
  logic [19:0]           total;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      for (int i = 0; i < TAPS; i++) begin
        prod[i] <= 16'(pix[i]) * 16'(wgt[i]);
      end
    end
    // one partial sum per kernel row
    if (ctrl.sum_en) begin
      for (int r = 0; r < 3; r++) begin
        psum[r] <= 18'(prod[3*r]) + 18'(prod[3*r+1]) + 18'(prod[3*r+2]);
      end
    end
  end

  always_comb begin
    total = 20'(psum[0]) + 20'(psum[1]) + 20'(psum[2]);
    sat   = (total > 20'd255) ? 8'hFF : total[7:0];
  end

endmodule

### rtl/rgb_conv3x3_valid.sv
// ----------------------------------------------------------------------------
// rgb_conv3x3_valid
// 3x3 convolution over a bgr raster stream, results for interior pixels only.
// ----------------------------------------------------------------------------
// pipeline: the pixel that completes a window moves from the stage 1 register
//   through the window, product and row-sum registers to the output register
// throughput: one pixel per clock while the output is not stalled; each pixel
//   does one read and one write of the two-row line memory, at the same column
// reset: counters, window, pipeline valids and configuration registers return
//   to reset values; the line memory is not cleared and needs no clearing pass
module rgb_conv3x3_valid import rgbc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [KERNEL_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          pix_blue,
  input  logic [7:0]          pix_green,
  input  logic [7:0]          pix_red,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_blue,
  output logic [7:0]          out_green,
  output logic [7:0]          out_red,
  output logic                frame_last
);

  // configuration
  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [KERNEL_W-1:0] kernel_top;
  logic [KERNEL_W-1:0] kernel_mid;
  logic [KERNEL_W-1:0] kernel_bot;
  logic                cfg_we;
  logic                restart;

  // frame position
  logic [COL_W-1:0]    col_count;
  logic [HEIGHT_W-1:0] row_count;
  logic [COL_W-1:0]    col_next;
  logic [HEIGHT_W-1:0] row_next;
  logic [WIDTH_W-1:0]  width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic                col_end;
  logic                row_end;
  logic                accept;

  // stage 1: pixel waiting for its line memory read
  logic                s1_valid;
  logic [PIX_W-1:0]    s1_pix;
  logic [COL_W-1:0]    s1_col;
  logic                s1_emit;
  logic                s1_last;
  logic                s1_ready;
  logic                s1_fire;
  logic [2*PIX_W-1:0]  line_rd;

  // stage 2: window, stage 3: products, stage 4: row sums
  logic [2:0][2:0][PIX_W-1:0] win;
  logic                v2, v3, v4;
  logic                l2, l3, l4;
  logic                s2_ready, s3_ready, s4_ready, out_load;

  tap_arr_t            wgt;
  tap_arr_t            tap_blue, tap_green, tap_red;
  lane_ctrl_t          lane_ctrl;
  logic [7:0]          sat_blue, sat_green, sat_red;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign restart   = cfg_we && (cfg_index inside {CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT});

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
      kernel_top   <= KERNEL_TOP_RST;
      kernel_mid   <= KERNEL_MID_RST;
      kernel_bot   <= KERNEL_BOT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        CFG_KERNEL_TOP:   kernel_top   <= cfg_data;
        CFG_KERNEL_MID:   kernel_mid   <= cfg_data;
        CFG_KERNEL_BOT:   kernel_bot   <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake chain, each stage moves when the next one has room
  assign out_load = !out_valid || out_ready;
  assign s4_ready = !v4 || out_load;
  assign s3_ready = !v3 || s4_ready;
  assign s2_ready = !v2 || s3_ready;
  assign s1_fire  = s1_valid && s2_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    width_eff = image_width;
    if (image_width < WIDTH_MIN) begin
      width_eff = WIDTH_MIN;
    end else if (image_width > WIDTH_MAX) begin
      width_eff = WIDTH_MAX;
    end
    height_eff = (image_height < HEIGHT_MIN) ? HEIGHT_MIN : image_height;
    col_end    = WIDTH_W'(col_count) >= width_eff - WIDTH_W'(1);
    row_end    = row_count >= height_eff - HEIGHT_W'(1);
    if (col_end) begin
      col_next = '0;
      row_next = row_end ? '0 : row_count + HEIGHT_W'(1);
    end else begin
      col_next = col_count + COL_W'(1);
      row_next = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_next;
      row_count <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
    if (accept) begin
      s1_pix  <= {pix_red, pix_green, pix_blue};
      s1_col  <= col_count;
      s1_emit <= (row_count >= HEIGHT_W'(2)) && (col_count >= COL_W'(2));
      s1_last <= row_end && col_end;
    end
  end

  // line memory word: older row in the low half, newer row in the high half
  rgbc_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_col),
    .wr_data ({s1_pix, line_rd[2*PIX_W-1:PIX_W]}),
    .rd_en   (accept),
    .rd_addr (col_count),
    .rd_data (line_rd)
  );

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      win <= '0;
    end else if (s1_fire) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= line_rd[PIX_W-1:0];
      win[1][2] <= line_rd[2*PIX_W-1:PIX_W];
      win[2][2] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_ready) begin
        v2 <= s1_valid && s1_emit;
      end
      if (s3_ready) begin
        v3 <= v2;
      end
      if (s4_ready) begin
        v4 <= v3;
      end
      if (out_load) begin
        out_valid <= v4;
      end
    end
    if (s1_fire) begin
      l2 <= s1_last;
    end
    if (s3_ready && v2) begin
      l3 <= l2;
    end
    if (s4_ready && v3) begin
      l4 <= l3;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        tap_blue[3*i+j]  = win[i][j][7:0];
        tap_green[3*i+j] = win[i][j][15:8];
        tap_red[3*i+j]   = win[i][j][23:16];
        wgt[3*i+j]       = (i == 0) ? kernel_top[8*j +: 8] :
                           (i == 1) ? kernel_mid[8*j +: 8] : kernel_bot[8*j +: 8];
      end
    end
    lane_ctrl.mul_en = s3_ready && v2;
    lane_ctrl.sum_en = s4_ready && v3;
  end

  rgbc_lane u_lane_blue (
    .clk  (clk),
    .ctrl (lane_ctrl),
    .pix  (tap_blue),
    .wgt  (wgt),
    .sat  (sat_blue)
  );

  rgbc_lane u_lane_green (
    .clk  (clk),
    .ctrl (lane_ctrl),
    .pix  (tap_green),
    .wgt  (wgt),
    .sat  (sat_green)
  );

  rgbc_lane u_lane_red (
    .clk  (clk),
    .ctrl (lane_ctrl),
    .pix  (tap_red),
    .wgt  (wgt),
    .sat  (sat_red)
  );

  // merge the three lanes into the output word
  always_ff @(posedge clk) begin
    if (out_load && v4) begin
      out_blue   <= sat_blue;
      out_green  <= sat_green;
      out_red    <= sat_red;
      frame_last <= l4;
    end
  end

endmodule
